[rtl/core/assert_macros.svh]
// Assertion helpers for the block's own checks.
// All checks sample on clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/hff_pkg.sv]
package hff_pkg;

	// position and count width: covers 0..127
	localparam int POS_W = 7;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_LOWA  = 8'h61;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic signed [7:0] prec_t;
	typedef logic [7:0]        char_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_SIZE,
		ST_PLACE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic count;
		logic size;
		logic place;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic size_zero;
		logic last;
		logic out_free;
	} status_t;

	// lowercase hex digit for one nibble
	function automatic char_t hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return CHAR_ZERO + {4'd0, nib};
		end else begin
			return CHAR_LOWA + {4'd0, nib - 4'd10};
		end
	endfunction

endpackage

[rtl/core/hff_ctrl.sv]
module hff_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  hff_pkg::status_t status,
	output hff_pkg::cmd_t    cmd
);
	import hff_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = ST_SIZE;
			end
			ST_SIZE: begin
				cmd.size = 1'b1;
				state_d  = ST_PLACE;
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				// drop an empty field without any beat
				state_d = status.size_zero ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/hff_datapath.sv]
module hff_datapath #(
	parameter int MAX_FIELD  = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hff_pkg::cmd_t         cmd,
	output hff_pkg::status_t      status,
	input  logic [VALUE_BITS-1:0] value,
	input  hff_pkg::pos_t         field_width,
	input  hff_pkg::prec_t        digit_precision,
	input  logic                  left_align,
	input  logic                  zero_pad,
	input  logic                  out_stall,
	output logic                  out_valid,
	output hff_pkg::char_t        text_char,
	output logic                  last_char
);
	import hff_pkg::*;

	localparam int NDIG_MAX = (VALUE_BITS + 3) / 4;
	localparam int NIB_W    = (NDIG_MAX > 1) ? $clog2(NDIG_MAX) : 1;
	localparam int NIB_CNT  = 1 << NIB_W;
	localparam int NIB_BITS = NIB_CNT * 4;
	localparam pos_t MAX_POS = POS_W'(MAX_FIELD);

	// captured item
	logic [NIB_BITS-1:0] value_q;
	pos_t                width_q;
	pos_t                prec_q;
	logic                prec_none_q;
	logic                left_q;
	logic                zpad_q;

	// field geometry
	pos_t  ndig_q;
	pos_t  body_q;
	pos_t  size_q;
	pos_t  zeros_q;
	pos_t  start_q;
	pos_t  dig_begin_q;
	pos_t  body_end_q;
	pos_t  emit_last_q;
	char_t padc_q;
	pos_t  p_q;

	// output register
	logic  out_valid_q;
	char_t text_char_q;
	logic  last_q;

	pos_t             ndig_d;
	pos_t             prec_eff;
	pos_t             body_d;
	pos_t             start_d;
	pos_t             idx_full;
	logic [NIB_W-1:0] nib_idx;
	char_t            char_d;
	logic             out_free;

	// capture the item, saturating width and precision
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q     <= NIB_BITS'(value);
			width_q     <= (field_width > MAX_POS) ? MAX_POS : field_width;
			prec_none_q <= digit_precision[7];
			prec_q      <= (POS_W'(digit_precision[6:0]) > MAX_POS) ? MAX_POS
				: POS_W'(digit_precision[6:0]);
			left_q      <= left_align;
			zpad_q      <= zero_pad;
		end
	end

	// count significant digits: highest nonzero nibble
	always_comb begin
		ndig_d = POS_W'(1);
		for (int i = 0; i < NDIG_MAX; i++) begin
			if (value_q[i*4 +: 4] != 4'd0) begin
				ndig_d = POS_W'(i + 1);
			end
		end
		// zero with zero precision prints no digits
		if (!prec_none_q && prec_q == '0 && value_q == '0) begin
			ndig_d = '0;
		end
	end

	assign prec_eff = prec_none_q ? '0 : prec_q;
	assign body_d   = (prec_eff > ndig_q) ? prec_eff : ndig_q;
	assign start_d  = left_q ? '0 : (size_q - body_q);

	// geometry, one step per state
	always_ff @(posedge clk) begin
		if (cmd.count) begin
			ndig_q <= ndig_d;
		end
		if (cmd.size) begin
			body_q  <= body_d;
			size_q  <= (width_q > body_d) ? width_q : body_d;
			zeros_q <= body_d - ndig_q;
		end
		if (cmd.place) begin
			start_q     <= start_d;
			dig_begin_q <= start_d + zeros_q;
			body_end_q  <= start_d + body_q;
			emit_last_q <= (size_q > MAX_POS) ? (MAX_POS - POS_W'(1))
				: (size_q - POS_W'(1));
			padc_q      <= (zpad_q && prec_none_q && !left_q) ? CHAR_ZERO : CHAR_SPACE;
		end
	end

	// pick the character at the current position
	assign idx_full = body_end_q - POS_W'(1) - p_q;
	assign nib_idx  = idx_full[NIB_W-1:0];

	always_comb begin
		if (p_q < start_q || p_q >= body_end_q) begin
			char_d = padc_q;
		end else if (p_q < dig_begin_q) begin
			char_d = CHAR_ZERO;
		end else begin
			char_d = hex_char(value_q[nib_idx*4 +: 4]);
		end
	end

	// advance the position and load the output beat
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			p_q <= '0;
		end else if (cmd.emit) begin
			p_q <= p_q + POS_W'(1);
		end
		if (cmd.emit) begin
			text_char_q <= char_d;
			last_q      <= (p_q == emit_last_q);
		end
	end

	// hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	assign status.size_zero = (size_q == '0);
	assign status.last      = (p_q == emit_last_q);
	assign status.out_free  = out_free;

	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign last_char = last_q;

endmodule

[rtl/core/hex_field_formatter.sv]
// Formats one unsigned number as printf "%x" text and sends it out one ASCII
// character per beat, the final character flagged by last_char. An item goes
// through setup steps (capture, digit count, field sizing, placement) and then
// sends min(field size, MAX_FIELD) characters; when the output side does not
// stall, the single output register sets the one-character-per-cycle pace. A
// new item is taken the cycle after the last character of the previous one is
// loaded. An empty field (value 0, zero precision, zero width) sends no beat.
module hex_field_formatter #(
	parameter int MAX_FIELD  = 64,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	input  hff_pkg::pos_t         field_width,
	input  hff_pkg::prec_t        digit_precision,
	input  logic                  left_align,
	input  logic                  zero_pad,
	output logic                  out_valid,
	input  logic                  out_stall,
	output hff_pkg::char_t        text_char,
	output logic                  last_char
);
	import hff_pkg::*;

	`include "assert_macros.svh"

	cmd_t    cmd;
	status_t status;

	hff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	hff_datapath #(
		.MAX_FIELD  (MAX_FIELD),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.value           (value),
		.field_width     (field_width),
		.digit_precision (digit_precision),
		.left_align      (left_align),
		.zero_pad        (zero_pad),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.text_char       (text_char),
		.last_char       (last_char)
	);

	// checks on controller and datapath together
	`ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one command active")
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")
	`ASSERT_NEXT(a_emit_shows_beat, cmd.emit, out_valid, "emitted beat not shown")
	`ASSERT_NOW(a_emit_needs_room, cmd.emit, !out_valid || !out_stall, "beat overwritten")

endmodule
